// File: design/bpc_pkg.sv
// Shared constants and types for the barometer pressure compensation pipeline.
package bpc_pkg;

    localparam int WORD_W = 16;
    localparam int PSI_W  = 24;
    localparam int TEMP_W = 16;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam int PCOMP_W = 37;
    localparam int KPA_W   = 33;

    localparam int PCOMP_STAGES = 3;
    localparam int KPA_STAGES   = 6;
    localparam int PSI_STAGES   = 8;
    localparam int NSTAGE       = PCOMP_STAGES + KPA_STAGES + PSI_STAGES;
    localparam int TEMP_CALC    = 4;
    localparam int TEMP_DLY     = NSTAGE - TEMP_CALC;

    localparam int KPA_DIV    = 1023;
    localparam int KPA_HALF   = 511;
    localparam int KPA_OFFSET = 209715200;

    localparam logic [23:0] PSI_NUM   = 24'd14503777;
    localparam logic [31:0] PSI_HALF  = 32'd3200000000;
    localparam logic [23:0] PSI_RECIP = 24'd11258999;
    localparam int          PSI_DEN_LO = 390625;
    localparam logic [23:0] PSI_POS_MAX = 24'h7FFFFF;
    localparam logic [23:0] PSI_NEG_MIN = 24'h800000;
    localparam logic [23:0] PSI_NEG_LIM = 24'd8388608;

    localparam int          TEMP_ZERO   = 498;
    localparam int          TEMP_HALF   = 53;
    localparam logic [15:0] TEMP_RECIP  = 16'd39199;
    localparam int          TEMP_DEN    = 107;
    localparam int          TEMP_OFFSET = 6400;

    typedef enum logic [1:0] {
        REG_A0  = 2'd0,
        REG_B1  = 2'd1,
        REG_B2  = 2'd2,
        REG_C12 = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic signed [15:0] a0;
        logic signed [15:0] b1;
        logic signed [15:0] b2;
        logic [13:0]        c12;
    } coeff_t;

endpackage

// File: design/bpc_raw_if.sv
// Raw sample channel: pressure and temperature register words.
interface bpc_raw_if import bpc_pkg::*;;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] pressure_word;
    logic [WORD_W-1:0] temperature_word;

    modport source (output valid, pressure_word, temperature_word, input ready);
    modport sink (input valid, pressure_word, temperature_word, output ready);
endinterface

// File: design/bpc_comp_if.sv
// Compensated result channel: pressure in PSI and temperature in Celsius.
interface bpc_comp_if import bpc_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [PSI_W-1:0]  pressure_psi_q16;
    logic signed [TEMP_W-1:0] temperature_c_q8;

    modport source (output valid, pressure_psi_q16, temperature_c_q8, input ready);
    modport sink (input valid, pressure_psi_q16, temperature_c_q8, output ready);
endinterface

// File: design/bpc_cfg_regs.sv
// APB coefficient register file.
module bpc_cfg_regs import bpc_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output coeff_t            coeff
);

    coeff_t   coeff_reg;
    coeff_t   coeff_next;
    reg_idx_t idx;
    logic     wr;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign coeff  = coeff_reg;

    always_comb
    begin
        coeff_next = coeff_reg;
        if (wr)
        begin
            case (idx)
                REG_A0:  coeff_next.a0  = pwdata[15:0];
                REG_B1:  coeff_next.b1  = pwdata[15:0];
                REG_B2:  coeff_next.b2  = pwdata[15:0];
                REG_C12: coeff_next.c12 = pwdata[13:0];
                default: coeff_next = coeff_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_A0:  prdata = {{16{coeff_reg.a0[15]}}, coeff_reg.a0};
            REG_B1:  prdata = {{16{coeff_reg.b1[15]}}, coeff_reg.b1};
            REG_B2:  prdata = {{16{coeff_reg.b2[15]}}, coeff_reg.b2};
            REG_C12: prdata = {18'd0, coeff_reg.c12};
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_reg <= '0;
        end
        else
        begin
            coeff_reg <= coeff_next;
        end
    end

endmodule

// File: design/bpc_pcomp.sv
// Compensated pressure sum in units of 2^-22, three register stages.
module bpc_pcomp import bpc_pkg::*; (
    input  logic                      clk,
    input  logic [PCOMP_STAGES-1:0]   en,
    input  coeff_t                    coeff,
    input  logic [WORD_W-1:0]         pressure_word,
    input  logic [WORD_W-1:0]         temperature_word,
    output logic signed [PCOMP_W-1:0] pcomp
);

    logic [9:0] padc;
    logic [9:0] tadc;

    logic signed [15:0] s0_a0_reg,   s0_a0_next;
    logic signed [25:0] s0_b1p_reg,  s0_b1p_next;
    logic [23:0]        s0_ct_reg,   s0_ct_next;
    logic signed [25:0] s0_b2t_reg,  s0_b2t_next;
    logic [9:0]         s0_padc_reg, s0_padc_next;

    logic [33:0]        s1_ctp_reg, s1_ctp_next;
    logic signed [35:0] s1_ab_reg,  s1_ab_next;
    logic signed [25:0] s1_b2t_reg, s1_b2t_next;

    logic signed [PCOMP_W-1:0] s2_pcomp_reg, s2_pcomp_next;

    assign padc  = pressure_word[15:6];
    assign tadc  = temperature_word[15:6];
    assign pcomp = s2_pcomp_reg;

    always_comb
    begin
        s0_a0_next   = $signed(coeff.a0);
        s0_b1p_next  = 26'($signed(coeff.b1) * $signed({1'b0, padc}));
        s0_ct_next   = 24'(coeff.c12 * tadc);
        s0_b2t_next  = 26'($signed(coeff.b2) * $signed({1'b0, tadc}));
        s0_padc_next = padc;
    end

    always_comb
    begin
        s1_ctp_next = 34'(s0_ct_reg * s0_padc_reg);
        s1_ab_next  = $signed({s0_a0_reg[15], s0_a0_reg, 19'd0})
                    + $signed({s0_b1p_reg[25], s0_b1p_reg, 9'd0});
        s1_b2t_next = s0_b2t_reg;
    end

    always_comb
    begin
        s2_pcomp_next = $signed({s1_ab_reg[35], s1_ab_reg})
                      + $signed({3'd0, s1_ctp_reg})
                      + $signed({{3{s1_b2t_reg[25]}}, s1_b2t_reg, 8'd0});
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s0_a0_reg   <= s0_a0_next;
            s0_b1p_reg  <= s0_b1p_next;
            s0_ct_reg   <= s0_ct_next;
            s0_b2t_reg  <= s0_b2t_next;
            s0_padc_reg <= s0_padc_next;
        end
        if (en[1])
        begin
            s1_ctp_reg <= s1_ctp_next;
            s1_ab_reg  <= s1_ab_next;
            s1_b2t_reg <= s1_b2t_next;
        end
        if (en[2])
        begin
            s2_pcomp_reg <= s2_pcomp_next;
        end
    end

endmodule

// File: design/bpc_kpa_div.sv
// Scale to kPa: rounded divide by 1023 through reciprocal series and one correction.
module bpc_kpa_div import bpc_pkg::*; (
    input  logic                      clk,
    input  logic [KPA_STAGES-1:0]     en,
    input  logic signed [PCOMP_W-1:0] pcomp,
    output logic signed [KPA_W-1:0]   kpa
);

    logic        s3_neg_reg, s3_neg_next;
    logic [35:0] s3_mag_reg, s3_mag_next;

    logic        s4_neg_reg, s4_neg_next;
    logic [41:0] s4_x_reg,   s4_x_next;

    logic        s5_neg_reg, s5_neg_next;
    logic [41:0] s5_y1_reg,  s5_y1_next;
    logic [22:0] s5_y2_reg,  s5_y2_next;
    logic [10:0] s5_xlo_reg, s5_xlo_next;

    logic        s6_neg_reg,  s6_neg_next;
    logic [31:0] s6_qest_reg, s6_qest_next;
    logic [10:0] s6_xlo_reg,  s6_xlo_next;
    logic [41:0] y_sum;

    logic        s7_neg_reg, s7_neg_next;
    logic [31:0] s7_q_reg,   s7_q_next;
    logic [10:0] rem;

    logic signed [KPA_W-1:0] s8_kpa_reg, s8_kpa_next;

    assign kpa = s8_kpa_reg;

    always_comb
    begin
        s3_neg_next = pcomp[PCOMP_W-1];
        s3_mag_next = pcomp[PCOMP_W-1] ? 36'(-pcomp) : pcomp[35:0];

        s4_neg_next = s3_neg_reg;
        s4_x_next   = {s3_mag_reg, 6'd0} + 42'(s3_mag_reg) + 42'(KPA_HALF);

        s5_neg_next = s4_neg_reg;
        s5_y1_next  = s4_x_reg + (s4_x_reg >> 10);
        s5_y2_next  = 23'(s4_x_reg >> 20) + 23'(s4_x_reg >> 30) + 23'(s4_x_reg >> 40);
        s5_xlo_next = s4_x_reg[10:0];

        y_sum        = s5_y1_reg + 42'(s5_y2_reg);
        s6_neg_next  = s5_neg_reg;
        s6_qest_next = y_sum[41:10];
        s6_xlo_next  = s5_xlo_reg;

        // remainder of x - 1023*q, kept modulo 2^11
        rem         = s6_xlo_reg - {s6_qest_reg[0], 10'd0} + s6_qest_reg[10:0];
        s7_neg_next = s6_neg_reg;
        s7_q_next   = s6_qest_reg + 32'(rem >= 11'(KPA_DIV));

        s8_kpa_next = s7_neg_reg ? 33'(KPA_OFFSET) - {1'b0, s7_q_reg}
                                 : 33'(KPA_OFFSET) + {1'b0, s7_q_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s3_neg_reg <= s3_neg_next;
            s3_mag_reg <= s3_mag_next;
        end
        if (en[1])
        begin
            s4_neg_reg <= s4_neg_next;
            s4_x_reg   <= s4_x_next;
        end
        if (en[2])
        begin
            s5_neg_reg <= s5_neg_next;
            s5_y1_reg  <= s5_y1_next;
            s5_y2_reg  <= s5_y2_next;
            s5_xlo_reg <= s5_xlo_next;
        end
        if (en[3])
        begin
            s6_neg_reg  <= s6_neg_next;
            s6_qest_reg <= s6_qest_next;
            s6_xlo_reg  <= s6_xlo_next;
        end
        if (en[4])
        begin
            s7_neg_reg <= s7_neg_next;
            s7_q_reg   <= s7_q_next;
        end
        if (en[5])
        begin
            s8_kpa_reg <= s8_kpa_next;
        end
    end

endmodule

// File: design/bpc_psi_scale.sv
// Scale kPa to PSI in Q8.16: multiply, reciprocal divide with correction, saturate.
module bpc_psi_scale import bpc_pkg::*; (
    input  logic                    clk,
    input  logic [PSI_STAGES-1:0]   en,
    input  logic signed [KPA_W-1:0] kpa,
    output logic signed [PSI_W-1:0] psi
);

    logic        s9_sign_reg, s9_sign_next;
    logic [31:0] s9_mag_reg,  s9_mag_next;

    logic        s10_sign_reg, s10_sign_next;
    logic [55:0] s10_n_reg,    s10_n_next;

    logic        s11_sign_reg, s11_sign_next;
    logic [41:0] s11_xx_reg,   s11_xx_next;
    logic [55:0] n_round;

    logic        s12_sign_reg, s12_sign_next;
    logic [44:0] s12_pl_reg,   s12_pl_next;
    logic [44:0] s12_ph_reg,   s12_ph_next;
    logic [19:0] s12_xlo_reg,  s12_xlo_next;

    logic        s13_sign_reg, s13_sign_next;
    logic [23:0] s13_qest_reg, s13_qest_next;
    logic [19:0] s13_xlo_reg,  s13_xlo_next;
    logic [45:0] pp_sum;

    logic        s14_sign_reg, s14_sign_next;
    logic [23:0] s14_qest_reg, s14_qest_next;
    logic [19:0] s14_rem_reg,  s14_rem_next;

    logic        s15_sign_reg, s15_sign_next;
    logic [23:0] s15_q_reg,    s15_q_next;

    logic [PSI_W-1:0] s16_psi_reg, s16_psi_next;

    assign psi = s16_psi_reg;

    always_comb
    begin
        s9_sign_next = kpa[KPA_W-1];
        s9_mag_next  = kpa[KPA_W-1] ? 32'(-kpa) : kpa[31:0];

        s10_sign_next = s9_sign_reg;
        s10_n_next    = 56'(s9_mag_reg * PSI_NUM);

        n_round       = s10_n_reg + 56'(PSI_HALF);
        s11_sign_next = s10_sign_reg;
        s11_xx_next   = n_round[55:14];

        s12_sign_next = s11_sign_reg;
        s12_pl_next   = 45'(s11_xx_reg[20:0] * PSI_RECIP);
        s12_ph_next   = 45'(s11_xx_reg[41:21] * PSI_RECIP);
        s12_xlo_next  = s11_xx_reg[19:0];

        pp_sum        = {1'b0, s12_ph_reg} + 46'(s12_pl_reg[44:21]);
        s13_sign_next = s12_sign_reg;
        s13_qest_next = pp_sum[44:21];
        s13_xlo_next  = s12_xlo_reg;

        // remainder of x - 390625*q, kept modulo 2^20
        s14_sign_next = s13_sign_reg;
        s14_qest_next = s13_qest_reg;
        s14_rem_next  = s13_xlo_reg - 20'(s13_qest_reg * PSI_DEN_LO);

        s15_sign_next = s14_sign_reg;
        s15_q_next    = s14_qest_reg + 24'(s14_rem_reg >= 20'(PSI_DEN_LO));

        if (s15_sign_reg)
        begin
            s16_psi_next = (s15_q_reg > PSI_NEG_LIM) ? PSI_NEG_MIN : 24'(-s15_q_reg);
        end
        else
        begin
            s16_psi_next = s15_q_reg[23] ? PSI_POS_MAX : s15_q_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s9_sign_reg <= s9_sign_next;
            s9_mag_reg  <= s9_mag_next;
        end
        if (en[1])
        begin
            s10_sign_reg <= s10_sign_next;
            s10_n_reg    <= s10_n_next;
        end
        if (en[2])
        begin
            s11_sign_reg <= s11_sign_next;
            s11_xx_reg   <= s11_xx_next;
        end
        if (en[3])
        begin
            s12_sign_reg <= s12_sign_next;
            s12_pl_reg   <= s12_pl_next;
            s12_ph_reg   <= s12_ph_next;
            s12_xlo_reg  <= s12_xlo_next;
        end
        if (en[4])
        begin
            s13_sign_reg <= s13_sign_next;
            s13_qest_reg <= s13_qest_next;
            s13_xlo_reg  <= s13_xlo_next;
        end
        if (en[5])
        begin
            s14_sign_reg <= s14_sign_next;
            s14_qest_reg <= s14_qest_next;
            s14_rem_reg  <= s14_rem_next;
        end
        if (en[6])
        begin
            s15_sign_reg <= s15_sign_next;
            s15_q_reg    <= s15_q_next;
        end
        if (en[7])
        begin
            s16_psi_reg <= s16_psi_next;
        end
    end

endmodule

// File: design/bpc_temp.sv
// Temperature in Q8.8 with a delay line that aligns it to the pressure result.
module bpc_temp import bpc_pkg::*; (
    input  logic                     clk,
    input  logic [NSTAGE-1:0]        en,
    input  logic [WORD_W-1:0]        temperature_word,
    output logic signed [TEMP_W-1:0] temp
);

    logic [9:0]  tadc;
    logic        tneg;
    logic [9:0]  dmag;

    logic        s0_neg_reg, s0_neg_next;
    logic [21:0] s0_mag_reg, s0_mag_next;

    logic        s1_neg_reg,  s1_neg_next;
    logic [14:0] s1_qest_reg, s1_qest_next;
    logic [7:0]  s1_mlo_reg,  s1_mlo_next;
    logic [36:0] prod;

    logic        s2_neg_reg, s2_neg_next;
    logic [14:0] s2_q_reg,   s2_q_next;
    logic [7:0]  rem;

    logic [TEMP_W-1:0] s3_temp_reg, s3_temp_next;

    logic [TEMP_W-1:0] dly_reg  [TEMP_DLY];
    logic [TEMP_W-1:0] dly_next [TEMP_DLY];

    assign tadc = temperature_word[15:6];
    assign temp = dly_reg[TEMP_DLY-1];

    always_comb
    begin
        tneg        = tadc > 10'(TEMP_ZERO);
        dmag        = tneg ? tadc - 10'(TEMP_ZERO) : 10'(TEMP_ZERO) - tadc;
        s0_neg_next = tneg;
        s0_mag_next = {dmag, 12'd0} + {2'd0, dmag, 10'd0} + 22'(TEMP_HALF);

        prod         = 37'(s0_mag_reg * TEMP_RECIP);
        s1_neg_next  = s0_neg_reg;
        s1_qest_next = prod[36:22];
        s1_mlo_next  = s0_mag_reg[7:0];

        rem         = s1_mlo_reg - 8'(s1_qest_reg * TEMP_DEN);
        s2_neg_next = s1_neg_reg;
        s2_q_next   = s1_qest_reg + 15'(rem >= 8'(TEMP_DEN));

        s3_temp_next = s2_neg_reg ? 16'(TEMP_OFFSET) - {1'b0, s2_q_reg}
                                  : 16'(TEMP_OFFSET) + {1'b0, s2_q_reg};
    end

    always_comb
    begin
        dly_next[0] = s3_temp_reg;
        for (int i = 1; i < TEMP_DLY; i++)
        begin
            dly_next[i] = dly_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s0_neg_reg <= s0_neg_next;
            s0_mag_reg <= s0_mag_next;
        end
        if (en[1])
        begin
            s1_neg_reg  <= s1_neg_next;
            s1_qest_reg <= s1_qest_next;
            s1_mlo_reg  <= s1_mlo_next;
        end
        if (en[2])
        begin
            s2_neg_reg <= s2_neg_next;
            s2_q_reg   <= s2_q_next;
        end
        if (en[3])
        begin
            s3_temp_reg <= s3_temp_next;
        end
        for (int i = 0; i < TEMP_DLY; i++)
        begin
            if (en[TEMP_CALC+i])
            begin
                dly_reg[i] <= dly_next[i];
            end
        end
    end

endmodule

// File: design/barometer_pressure_compensation.sv
// Top level of the barometer pressure compensation pipeline.
//
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+------------------------------------------
//  raw      | in  | valid/ready            | pressure_word[15:0], temperature_word[15:0]
//  comp     | out | valid/ready            | pressure_psi_q16[23:0], temperature_c_q8[15:0]
//  APB      | in  | psel/penable/pwrite    | paddr[3:0], pwdata[31:0], prdata[31:0]
//
//  One sample per cycle while the output is not stalled; each sample passes through the
//  17-stage register chain (product terms, divide by 1023, PSI multiply and divide).
//  A stage advances when it is empty or the stage after it advances; the last stage
//  holds the result until it is transferred, and bubbles close up behind a stall.
//  Reset clears the stage valid bits and the coefficient registers.
module barometer_pressure_compensation import bpc_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    bpc_raw_if.sink           raw,
    bpc_comp_if.source        comp
);

    localparam int KPA_LO = PCOMP_STAGES;
    localparam int KPA_HI = PCOMP_STAGES + KPA_STAGES - 1;
    localparam int PSI_LO = NSTAGE - PSI_STAGES;

    coeff_t                    coeff;
    logic [NSTAGE-1:0]         en;
    logic [NSTAGE-1:0]         valid_reg;
    logic [NSTAGE-1:0]         valid_next;
    logic signed [PCOMP_W-1:0] pcomp;
    logic signed [KPA_W-1:0]   kpa;
    logic signed [PSI_W-1:0]   psi;
    logic signed [TEMP_W-1:0]  temp;

    bpc_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coeff   (coeff)
    );

    bpc_pcomp u_pcomp (
        .clk              (clk),
        .en               (en[PCOMP_STAGES-1:0]),
        .coeff            (coeff),
        .pressure_word    (raw.pressure_word),
        .temperature_word (raw.temperature_word),
        .pcomp            (pcomp)
    );

    bpc_kpa_div u_kpa (
        .clk   (clk),
        .en    (en[KPA_HI:KPA_LO]),
        .pcomp (pcomp),
        .kpa   (kpa)
    );

    bpc_psi_scale u_psi (
        .clk (clk),
        .en  (en[NSTAGE-1:PSI_LO]),
        .kpa (kpa),
        .psi (psi)
    );

    bpc_temp u_temp (
        .clk              (clk),
        .en               (en),
        .temperature_word (raw.temperature_word),
        .temp             (temp)
    );

    // advance a stage when it or any later stage has a hole, or the result is taken
    for (genvar k = 0; k < NSTAGE; k++)
    begin : g_en
        assign en[k] = comp.ready || !(&valid_reg[NSTAGE-1:k]);
    end

    always_comb
    begin
        valid_next[0] = raw.valid;
        for (int k = 1; k < NSTAGE; k++)
        begin
            valid_next[k] = valid_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NSTAGE; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_next[k];
                end
            end
        end
    end

    assign raw.ready             = en[0];
    assign comp.valid            = valid_reg[NSTAGE-1];
    assign comp.pressure_psi_q16 = psi;
    assign comp.temperature_c_q8 = temp;

`ifndef SYNTH
    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |->
            ($countones(valid_reg) == $past($countones(valid_reg))
                + $past(int'(raw.valid && raw.ready))
                - $past(int'(comp.valid && comp.ready))))
        else $error("pipeline occupancy does not match transfers");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !raw.ready |-> (&valid_reg && !comp.ready))
        else $error("input stalled while the pipeline has a free stage");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (comp.valid && !comp.ready) |=> (valid_reg[NSTAGE-1] && $stable(psi) && $stable(temp)))
        else $error("held result changed before transfer");
`endif

endmodule
